// ===== sv/lcfp_pkg.sv =====
// lcfp_pkg: types and constants shared by the led command frame parser
// holds the configuration struct, the event codes and the result struct
// no dependencies
package lcfp_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_IDX_HEADER  = 8'd0;
  localparam logic [7:0] CFG_IDX_FOOTER  = 8'd1;
  localparam logic [7:0] CFG_IDX_CONTROL = 8'd2;
  localparam logic [7:0] CFG_IDX_VERSION = 8'd3;

  // configuration reset values
  localparam logic [7:0] HEADER_RESET  = 8'h5a;
  localparam logic [7:0] FOOTER_RESET  = 8'ha5;
  localparam logic [7:0] CONTROL_RESET = 8'h01;
  localparam logic [7:0] VERSION_RESET = 8'h00;

  // captured payload: frame bytes 3 to 7
  localparam int PAYLOAD_BYTES = 5;
  localparam int PAYLOAD_FIRST = 3;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] footer_byte;
    logic [7:0] control_type;
    logic [7:0] version_type;
  } cfg_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_CONTROL    = 3'd1,
    EV_VERSION    = 3'd2,
    EV_OTHER      = 3'd3,
    EV_SUM_BAD    = 3'd4,
    EV_FOOTER_BAD = 3'd5,
    EV_OVERFLOW   = 3'd6
  } ev_t;

  typedef struct packed {
    ev_t        event_res;
    logic [7:0] lamp_mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] blink_period;
  } result_t;

endpackage

// ===== sv/lcfp_cfg_regs.sv =====
// lcfp_cfg_regs: configuration registers of the frame parser
// written through an index/data port; depends on lcfp_pkg
module lcfp_cfg_regs import lcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte  <= HEADER_RESET;
      cfg.footer_byte  <= FOOTER_RESET;
      cfg.control_type <= CONTROL_RESET;
      cfg.version_type <= VERSION_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IDX_HEADER:  cfg.header_byte  <= wr_data;
        CFG_IDX_FOOTER:  cfg.footer_byte  <= wr_data;
        CFG_IDX_CONTROL: cfg.control_type <= wr_data;
        CFG_IDX_VERSION: cfg.version_type <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/lcfp_core.sv =====
// lcfp_core: frame state and per-byte parse logic
// takes one byte when en is high and gives its result combinationally; depends on lcfp_pkg
module lcfp_core import lcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    ST_HUNT  = 2'b01,
    ST_FRAME = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] byte_index, byte_index_next, nidx;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       frame_kind, frame_kind_next;
  logic [7:0]       sum_two_back, sum_two_back_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic [7:0]       payload_bytes [PAYLOAD_BYTES];
  logic [7:0]       payload_bytes_next [PAYLOAD_BYTES];
  ev_t              ev;

  assign nidx = byte_index + 1'b1;

  // parse one byte
  always_comb begin
    state_next         = state;
    byte_index_next    = byte_index;
    frame_length_next  = frame_length;
    frame_kind_next    = frame_kind;
    sum_two_back_next  = sum_two_back;
    previous_byte_next = previous_byte;
    payload_bytes_next = payload_bytes;
    ev                 = EV_NONE;
    case (state)
      ST_HUNT: begin
        if (rx_byte == cfg.header_byte) begin
          state_next         = ST_FRAME;
          byte_index_next    = '0;
          sum_two_back_next  = '0;
          previous_byte_next = rx_byte;
        end
      end
      ST_FRAME: begin
        byte_index_next = nidx;
        // capture length, type and payload bytes
        if (nidx == IDX_W'(1)) frame_length_next = rx_byte;
        if (nidx == IDX_W'(2)) frame_kind_next = rx_byte;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
          if (nidx == IDX_W'(k + PAYLOAD_FIRST)) payload_bytes_next[k] = rx_byte;
        end
        // footer position, overflow or keep summing
        if ((9'(nidx) + 9'd1) == {1'b0, frame_length_next}) begin
          if (rx_byte != cfg.footer_byte)                 ev = EV_FOOTER_BAD;
          else if (sum_two_back != previous_byte)         ev = EV_SUM_BAD;
          else if (frame_kind_next == cfg.control_type)   ev = EV_CONTROL;
          else if (frame_kind_next == cfg.version_type)   ev = EV_VERSION;
          else                                            ev = EV_OTHER;
          state_next      = ST_HUNT;
          byte_index_next = '0;
        end else if (nidx >= IDX_W'(MAX_FRAME_BYTES - 1)) begin
          ev              = EV_OVERFLOW;
          state_next      = ST_HUNT;
          byte_index_next = '0;
        end else begin
          sum_two_back_next  = sum_two_back + previous_byte;
          previous_byte_next = rx_byte;
        end
      end
      default: begin
        state_next      = ST_HUNT;
        byte_index_next = '0;
      end
    endcase
  end

  // result: payload only for good frames
  always_comb begin
    result           = '0;
    result.event_res = ev;
    if (ev == EV_CONTROL || ev == EV_VERSION || ev == EV_OTHER) begin
      result.lamp_mode    = payload_bytes_next[0];
      result.red          = payload_bytes_next[1];
      result.green        = payload_bytes_next[2];
      result.blue         = payload_bytes_next[3];
      result.blink_period = payload_bytes_next[4];
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      byte_index    <= '0;
      frame_length  <= '0;
      frame_kind    <= '0;
      sum_two_back  <= '0;
      previous_byte <= '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) payload_bytes[k] <= '0;
    end else if (en) begin
      state         <= state_next;
      byte_index    <= byte_index_next;
      frame_length  <= frame_length_next;
      frame_kind    <= frame_kind_next;
      sum_two_back  <= sum_two_back_next;
      previous_byte <= previous_byte_next;
      payload_bytes <= payload_bytes_next;
    end
  end

  // index stays short of the overflow point between bytes
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index < IDX_W'(MAX_FRAME_BYTES - 1))
    else $error("byte index past overflow point");

  // hunting always restarts at index zero
  a_hunt_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_HUNT |-> byte_index == '0)
    else $error("nonzero index while hunting");

  // any reported event ends the frame
  a_event_ends: assert property (@(posedge clk) disable iff (rst)
    en && ev != EV_NONE |=> state == ST_HUNT)
    else $error("frame still open after event");

endmodule

// ===== sv/led_command_frame_parser_unit.sv =====
// led_command_frame_parser_unit: top level of the led command frame parser
// input register, parse core and result register; depends on lcfp_pkg,
// lcfp_cfg_regs and lcfp_core
//
// Usage:
//   rx channel (rx_valid, rx_stall, rx_byte) takes one received byte per item.
//   res channel (res_valid, res_stall, event_res and the five payload fields)
//   gives exactly one result item for every byte: event 0 while nothing ends,
//   otherwise the frame outcome, with payload fields zero unless the frame was good.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes header,
//   footer, control type and version type; cfg_ready is always high.
// Path: an accepted byte passes the input register, then the parse logic into the
//   result register. Throughput: one byte per cycle while res_stall is low;
//   the parse is a few compares and one 8-bit add.
// Reset: synchronous rst empties both registers, restores the default codes
//   and returns the parser to hunting for a header.
// Stall: while res_stall holds a result, the input register still takes one
//   more byte; rx_stall rises only when both registers are full.
module led_command_frame_parser_unit import lcfp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] event_res,
  output logic [7:0] lamp_mode,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] blink_period,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg;
  result_t    result;
  result_t    res;
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  assign cfg_ready = 1'b1;

  // configuration registers
  lcfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item moves from input register to result register
  assign advance  = in_full && (!res_valid || !res_stall);
  assign rx_stall = in_full && res_valid && res_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  // parse core
  lcfp_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

  assign event_res    = res.event_res;
  assign lamp_mode    = res.lamp_mode;
  assign red          = res.red;
  assign green        = res.green;
  assign blue         = res.blue;
  assign blink_period = res.blink_period;

  // a held input item is not dropped
  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("input item lost");

  // a parsed item always lands in the result register
  a_adv_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("parsed item not presented");

  // payload only accompanies good frames
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !(res.event_res == EV_CONTROL || res.event_res == EV_VERSION ||
                   res.event_res == EV_OTHER)
    |-> {lamp_mode, red, green, blue, blink_period} == '0)
    else $error("payload on non-frame event");

  // event codes stay in range
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> event_res <= EV_OVERFLOW)
    else $error("event code out of range");

endmodule
